[src/qau_pkg.sv]
// Shared types, command codes and the Hamilton product term tables of the quaternion unit.
package qau_pkg;

	typedef enum logic [2:0] {
		CMD_MUL   = 3'd0,
		CMD_SCALE = 3'd1,
		CMD_CONJ  = 3'd2,
		CMD_LEN   = 3'd3,
		CMD_NORM  = 3'd4,
		CMD_EQ    = 3'd5
	} cmd_e;

	typedef enum logic [1:0] {
		FLT_NONE = 2'd0,
		FLT_SAT  = 2'd1,
		FLT_ZERO = 2'd2
	} fault_e;

	// What a lane does with its operands in the last of its three stages.
	typedef enum logic [1:0] {
		LM_ZERO = 2'd0,
		LM_FIX  = 2'd1,
		LM_NEG  = 2'd2,
		LM_PASS = 2'd3
	} lane_mode_e;

	typedef struct packed {
		lane_mode_e mode;
		logic [3:0] neg;
	} lane_ctl_t;

	// Operand indexes (0 x, 1 y, 2 z, 3 w) of the four product terms of each result lane.
	localparam logic [1:0] HAM_A [4][4] = '{
		'{2'd0, 2'd3, 2'd1, 2'd2},
		'{2'd1, 2'd3, 2'd2, 2'd0},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] HAM_B [4][4] = '{
		'{2'd3, 2'd0, 2'd2, 2'd1},
		'{2'd3, 2'd1, 2'd0, 2'd2},
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	// Bit s set means term s is subtracted.
	localparam logic [3:0] HAM_NEG [4] = '{4'b1000, 4'b1000, 4'b1000, 4'b1110};

endpackage

[src/qau_if.sv]
// Request and response channel interfaces of the quaternion unit.
interface qau_req_if #(parameter int CW = 32);
	logic                 valid;
	logic                 ready;
	logic [2:0]           command;
	logic signed [CW-1:0] a_x;
	logic signed [CW-1:0] a_y;
	logic signed [CW-1:0] a_z;
	logic signed [CW-1:0] a_w;
	logic signed [CW-1:0] b_x;
	logic signed [CW-1:0] b_y;
	logic signed [CW-1:0] b_z;
	logic signed [CW-1:0] b_w;
	logic signed [CW-1:0] factor;

	modport source (output valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor,
		input ready);
	modport sink (input valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor,
		output ready);
endinterface

interface qau_rsp_if #(parameter int CW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] r_x;
	logic signed [CW-1:0] r_y;
	logic signed [CW-1:0] r_z;
	logic signed [CW-1:0] r_w;
	logic [CW-1:0]        magnitude;
	logic                 are_equal;
	logic [1:0]           fault;

	modport source (output valid, r_x, r_y, r_z, r_w, magnitude, are_equal, fault,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, r_w, magnitude, are_equal, fault,
		output ready);
endinterface

[src/qau_lane.sv]
// One arithmetic lane: four products, a signed sum, then shift and saturate, or negate or pass its first operand.
module qau_lane #(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  qau_pkg::lane_ctl_t     ctl,
	input  logic signed [CW-1:0]   x [4],
	input  logic signed [CW-1:0]   y [4],
	output logic signed [2*CW+1:0] sum,
	output logic signed [CW-1:0]   r,
	output logic                   ovf
);
	import qau_pkg::*;

	localparam int PW = 2 * CW;
	localparam int SW = 2 * CW + 2;
	localparam logic signed [SW-1:0] SMAX_W = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN_W = ~SMAX_W;
	localparam logic signed [CW-1:0] SMAX_C = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN_C = {1'b1, {(CW-1){1'b0}}};

	logic signed [PW-1:0] p_s1 [4];
	lane_ctl_t            ctl_s1, ctl_s2;
	logic signed [CW-1:0] v0_s1, v0_s2;
	logic signed [SW-1:0] sum_s2, sum_d, sh;
	logic signed [CW-1:0] r_d;
	logic                 ovf_d;
	logic signed [CW-1:0] r_s3;
	logic                 ovf_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				p_s1[i] <= $signed(PW'(x[i])) * $signed(PW'(y[i]));
			end
			ctl_s1 <= ctl;
			v0_s1  <= x[0];
		end
	end

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < 4; i++) begin
			if (ctl_s1.neg[i]) begin
				sum_d = sum_d - $signed(SW'(p_s1[i]));
			end else begin
				sum_d = sum_d + $signed(SW'(p_s1[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_d;
			ctl_s2 <= ctl_s1;
			v0_s2  <= v0_s1;
		end
	end

	assign sh = sum_s2 >>> FB;

	always_comb begin
		r_d   = '0;
		ovf_d = 1'b0;
		case (ctl_s2.mode)
			LM_FIX: begin
				if (sh > SMAX_W) begin
					r_d   = SMAX_C;
					ovf_d = 1'b1;
				end else if (sh < SMIN_W) begin
					r_d   = SMIN_C;
					ovf_d = 1'b1;
				end else begin
					r_d = sh[CW-1:0];
				end
			end
			LM_NEG: begin
				if (v0_s2 == SMIN_C) begin
					r_d   = SMAX_C;
					ovf_d = 1'b1;
				end else begin
					r_d = -v0_s2;
				end
			end
			LM_PASS: r_d = v0_s2;
			default: r_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3   <= r_d;
			ovf_s3 <= ovf_d;
		end
	end

	assign sum = sum_s2;
	assign r   = r_s3;
	assign ovf = ovf_s3;
endmodule

[src/qau_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qau_sqrt #(
	parameter int CW = 32
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*CW+1:0]     sq,
	output logic [CW:0]         root
);
	localparam int RB = CW + 1;
	localparam int SW = 2 * RB;

	logic [RB-1:0] rt_q [RB];
	logic [SW-1:0] rm_q [RB];

	for (genvar j = 0; j < RB; j++) begin : g_stage
		localparam int K = RB - 1 - j;
		logic [RB-1:0] rt_in;
		logic [SW-1:0] rm_in;
		logic [SW-1:0] trial;

		if (j == 0) begin : g_first
			assign rt_in = '0;
			assign rm_in = sq;
		end else begin : g_next
			assign rt_in = rt_q[j-1];
			assign rm_in = rm_q[j-1];
		end

		// (r + 2^K)^2 - r^2, with r holding only bits above K.
		assign trial = (SW'(rt_in) << (K + 1)) | (SW'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rm_in >= trial) begin
					rm_q[j] <= rm_in - trial;
					rt_q[j] <= rt_in | (RB'(1) << K);
				end else begin
					rm_q[j] <= rm_in;
					rt_q[j] <= rt_in;
				end
			end
		end
	end

	assign root = rt_q[RB-1];
endmodule

[src/qau_div.sv]
// Pipelined restoring divider forming (m * 2^FB) / d, one quotient bit per stage.
module qau_div #(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [CW-1:0] m,
	input  logic [CW:0]   d,
	output logic [FB:0]   q,
	output logic [CW:0]   d_out
);
	localparam int QB = FB + 1;
	localparam int RB = CW + 1;
	localparam int DW = CW + FB + 1;

	logic [DW-1:0] rm_q [QB];
	logic [QB-1:0] q_q  [QB];
	logic [RB-1:0] d_q  [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = FB - j;
		logic [DW-1:0] rm_in;
		logic [QB-1:0] q_in;
		logic [RB-1:0] d_in;
		logic [DW-1:0] trial;

		if (j == 0) begin : g_first
			assign rm_in = DW'(m) << FB;
			assign q_in  = '0;
			assign d_in  = d;
		end else begin : g_next
			assign rm_in = rm_q[j-1];
			assign q_in  = q_q[j-1];
			assign d_in  = d_q[j-1];
		end

		assign trial = DW'(d_in) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				d_q[j] <= d_in;
				if (rm_in >= trial) begin
					rm_q[j] <= rm_in - trial;
					q_q[j]  <= q_in | (QB'(1) << K);
				end else begin
					rm_q[j] <= rm_in;
					q_q[j]  <= q_in;
				end
			end
		end
	end

	assign q     = q_q[QB-1];
	assign d_out = d_q[QB-1];
endmodule

[src/quaternion_arithmetic_unit.sv]
// Top level of the quaternion unit: operand routing, lanes, root and divide pipes, merge.
// The unit takes one request beat per cycle while the pipeline moves and answers each with
// exactly one response beat, in order. Every command walks the same fixed pipeline: three
// lane stages (multiply, sum, shift and saturate), COMPONENT_WIDTH+1 square-root stages,
// FRACTION_BITS+1 divide stages and the output register. The default format is Q16.16.
// Four lanes each own one result component and carry four 32x32 multipliers; the Hamilton
// product, scaling and the squares for the length all share them, while conjugate negates
// or passes the components through the lanes. Length and normalize then run through the
// bit-per-stage root and the four divide pipes. The whole pipeline moves forward together;
// it holds only when its last stage carries a result while the output register is still
// full and not being taken, so bubbles keep draining and new request beats keep being
// accepted while a response waits.
module quaternion_arithmetic_unit #(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 16
) (
	input logic       clk,
	input logic       arst_n,
	qau_req_if.sink   req,
	qau_rsp_if.source rsp
);
	import qau_pkg::*;

	localparam int CW    = COMPONENT_WIDTH;
	localparam int FB    = FRACTION_BITS;
	localparam int RB    = CW + 1;
	localparam int QB    = FB + 1;
	localparam int SW    = 2 * CW + 2;
	localparam int SSW   = 2 * CW + 1;
	localparam int XW    = ((QB > CW) ? QB : CW) + 1;
	localparam int NSIDE = RB + QB;

	localparam logic signed [CW-1:0] SMAX_C = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN_C = {1'b1, {(CW-1){1'b0}}};
	localparam logic [XW-1:0]        HALF_X = XW'(1) << (CW - 1);
	localparam logic [XW-1:0]        SMAX_X = HALF_X - XW'(1);

	// Per-beat bookkeeping that rides next to the arithmetic.
	typedef struct packed {
		cmd_e                cmd;
		logic                eq;
		logic [3:0]          neg;
		logic [3:0][CW-1:0]  amag;
	} head_t;

	typedef struct packed {
		head_t               hd;
		logic [3:0][CW-1:0]  r;
		logic                ovf;
	} side_t;

	typedef struct packed {
		logic [3:0][CW-1:0]  r;
		logic [CW-1:0]       mag;
		logic                eq;
		fault_e              fault;
	} out_t;

	logic                 en;
	logic                 take;
	cmd_e                 cmd;
	logic signed [CW-1:0] a [4];
	logic signed [CW-1:0] b [4];

	// The request is accepted whenever the pipeline moves.
	assign take      = req.valid && en;
	assign req.ready = en;
	assign cmd       = cmd_e'(req.command);

	assign a[0] = req.a_x;
	assign a[1] = req.a_y;
	assign a[2] = req.a_z;
	assign a[3] = req.a_w;
	assign b[0] = req.b_x;
	assign b[1] = req.b_y;
	assign b[2] = req.b_z;
	assign b[3] = req.b_w;

	// Operand routing: each lane gets four multiplier operand pairs and a mode.
	logic signed [CW-1:0] opx [4][4];
	logic signed [CW-1:0] opy [4][4];
	lane_ctl_t            lctl [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			lctl[l].mode = LM_ZERO;
			lctl[l].neg  = '0;
			for (int s = 0; s < 4; s++) begin
				opx[l][s] = '0;
				opy[l][s] = '0;
			end
		end
		case (cmd)
			CMD_MUL: begin
				for (int l = 0; l < 4; l++) begin
					lctl[l].mode = LM_FIX;
					lctl[l].neg  = HAM_NEG[l];
					for (int s = 0; s < 4; s++) begin
						opx[l][s] = a[HAM_A[l][s]];
						opy[l][s] = b[HAM_B[l][s]];
					end
				end
			end
			CMD_SCALE: begin
				for (int l = 0; l < 4; l++) begin
					lctl[l].mode = LM_FIX;
					opx[l][0]    = a[l];
					opy[l][0]    = req.factor;
				end
			end
			CMD_CONJ: begin
				for (int l = 0; l < 4; l++) begin
					lctl[l].mode = (l == 3) ? LM_PASS : LM_NEG;
					opx[l][0]    = a[l];
				end
			end
			CMD_LEN, CMD_NORM: begin
				// Each lane squares its own component; the squares are summed after stage two.
				for (int l = 0; l < 4; l++) begin
					lctl[l].mode = LM_FIX;
					opx[l][0]    = a[l];
					opy[l][0]    = a[l];
				end
			end
			default: begin
				for (int l = 0; l < 4; l++) begin
					lctl[l].mode = LM_ZERO;
				end
			end
		endcase
	end

	logic signed [SW-1:0] lsum [4];
	logic signed [CW-1:0] lr   [4];
	logic                 lovf [4];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		qau_lane #(.CW(CW), .FB(FB)) u_lane (
			.clk (clk),
			.en  (en),
			.ctl (lctl[l]),
			.x   (opx[l]),
			.y   (opy[l]),
			.sum (lsum[l]),
			.r   (lr[l]),
			.ovf (lovf[l])
		);
	end

	// Bookkeeping through the three lane stages.
	head_t hd_d, hd_s1, hd_s2, hd_s3;
	logic  v_s1, v_s2, v_s3;

	always_comb begin
		hd_d.cmd = cmd;
		hd_d.eq  = (cmd == CMD_EQ) && (a[0] == b[0]) && (a[1] == b[1]) &&
			(a[2] == b[2]) && (a[3] == b[3]);
		for (int i = 0; i < 4; i++) begin
			hd_d.neg[i]  = a[i][CW-1];
			hd_d.amag[i] = a[i][CW-1] ? CW'(-a[i]) : CW'(a[i]);
		end
	end

	// Sum of squares over the four lanes, registered alongside the lane results.
	logic [SSW-1:0] sumsq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s1    <= hd_d;
			hd_s2    <= hd_s1;
			hd_s3    <= hd_s2;
			sumsq_s3 <= lsum[0][SSW-1:0] + lsum[1][SSW-1:0] + lsum[2][SSW-1:0] +
				lsum[3][SSW-1:0];
		end
	end

	// Root and divide pipes, with a side line of the same depth for everything else.
	side_t       side_q [NSIDE];
	logic        sv_q   [NSIDE];
	logic [RB-1:0] root;
	logic [QB-1:0] quo  [4];
	logic [RB-1:0] dlen [4];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0].hd  <= hd_s3;
			side_q[0].ovf <= lovf[0] | lovf[1] | lovf[2] | lovf[3];
			for (int i = 0; i < 4; i++) begin
				side_q[0].r[i] <= lr[i];
			end
			for (int k = 1; k < NSIDE; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 0; k < NSIDE; k++) begin
				sv_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= take;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			sv_q[0] <= v_s3;
			for (int k = 1; k < NSIDE; k++) begin
				sv_q[k] <= sv_q[k-1];
			end
		end
	end

	qau_sqrt #(.CW(CW)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.sq   (SW'(sumsq_s3)),
		.root (root)
	);

	for (genvar l = 0; l < 4; l++) begin : g_div
		qau_div #(.CW(CW), .FB(FB)) u_div (
			.clk   (clk),
			.en    (en),
			.m     (side_q[RB-1].hd.amag[l]),
			.d     (root),
			.q     (quo[l]),
			.d_out (dlen[l])
		);
	end

	// Merge: pick the result of the command from the lanes, the root, the quotients or the equality flag.
	side_t         last;
	logic          v_last;
	logic [RB-1:0] len;
	logic          mag_sat;
	logic [CW-1:0] mag_v;
	logic [XW-1:0] qx;
	logic          ovf_m;
	out_t          out_d;

	assign last    = side_q[NSIDE-1];
	assign v_last  = sv_q[NSIDE-1];
	assign len     = dlen[0];
	assign mag_sat = len[CW];
	assign mag_v   = mag_sat ? '1 : len[CW-1:0];

	always_comb begin
		out_d.r     = '0;
		out_d.mag   = '0;
		out_d.eq    = 1'b0;
		out_d.fault = FLT_NONE;
		ovf_m       = 1'b0;
		qx          = '0;
		case (last.hd.cmd)
			CMD_MUL, CMD_SCALE, CMD_CONJ: begin
				out_d.r = last.r;
				ovf_m   = last.ovf;
			end
			CMD_LEN: begin
				out_d.mag = mag_v;
				ovf_m     = mag_sat;
			end
			CMD_NORM: begin
				if (len != '0) begin
					out_d.mag = mag_v;
					ovf_m     = mag_sat;
					for (int i = 0; i < 4; i++) begin
						qx = XW'(quo[i]);
						if (last.hd.neg[i]) begin
							if (qx > HALF_X) begin
								out_d.r[i] = SMIN_C;
								ovf_m      = 1'b1;
							end else begin
								out_d.r[i] = -qx[CW-1:0];
							end
						end else begin
							if (qx > SMAX_X) begin
								out_d.r[i] = SMAX_C;
								ovf_m      = 1'b1;
							end else begin
								out_d.r[i] = qx[CW-1:0];
							end
						end
					end
				end
			end
			CMD_EQ: out_d.eq = last.hd.eq;
			default: out_d.r = '0;
		endcase
		if (last.hd.cmd == CMD_NORM && len == '0) begin
			out_d.fault = FLT_ZERO;
		end else if (ovf_m) begin
			out_d.fault = FLT_SAT;
		end
	end

	// Output register; the pipeline stalls only when it would overwrite a waiting beat.
	out_t out_q;
	logic out_v_q;

	assign en = !(v_last && out_v_q && !rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (v_last && en) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_last && en) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.r_x       = out_q.r[0];
	assign rsp.r_y       = out_q.r[1];
	assign rsp.r_z       = out_q.r[2];
	assign rsp.r_w       = out_q.r[3];
	assign rsp.magnitude = out_q.mag;
	assign rsp.are_equal = out_q.eq;
	assign rsp.fault     = out_q.fault;

	// A zero-length normalize reports nothing but its fault.
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.fault == FLT_ZERO) |-> (out_q.mag == '0 && out_q.r == '0))
		else $error("zero-length normalize carries data");

	// An equality answer never comes with component data or a fault.
	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.eq) |-> (out_q.r == '0 && out_q.fault == FLT_NONE))
		else $error("equality beat carries data");

	// A stalled last stage keeps its item until the output register frees.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_last && !en) |=> (v_last && $stable(last)))
		else $error("last stage lost its item during a stall");
endmodule

[test/quaternion_arithmetic_unit_tb.sv]
// Self-checking testbench of the quaternion unit: directed table, random beats, idle and stall phases.
module quaternion_arithmetic_unit_tb;
	import qau_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LATENCY = 60;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;
	localparam logic signed [31:0] ONE = 32'sh00010000;

	// One request beat as the sender sees it.
	typedef struct {
		logic [2:0]         command;
		logic signed [31:0] a [4];
		logic signed [31:0] b [4];
		logic signed [31:0] factor;
	} quat_req_t;

	// One response beat; index 0 x, 1 y, 2 z, 3 w.
	typedef struct {
		logic signed [31:0] r [4];
		logic [31:0]        magnitude;
		logic               are_equal;
		logic [1:0]         fault;
	} quat_rsp_t;

	// A row of the directed table. When known is set the response is typed in by hand.
	typedef struct {
		quat_req_t req;
		bit        known;
		quat_rsp_t rsp;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qau_req_if #(.CW(CW)) req_ch ();
	qau_rsp_if #(.CW(CW)) rsp_ch ();

	quaternion_arithmetic_unit #(.COMPONENT_WIDTH(CW), .FRACTION_BITS(FB)) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	always #10 clk = ~clk;

	quat_rsp_t expected_rsps [$];
	int        error_count = 0;
	int        send_idle_pct = 23;
	int        recv_idle_pct = 65;
	bit        recv_hold = 1'b0;
	bit        stimulus_done = 1'b0;
	int        quiet_cycles = 0;

	// Saturate a wide signed value into the component range.
	function automatic logic signed [31:0] saturate(input logic signed [127:0] v, inout bit ovf);
		if (v > 128'(SMAX)) begin
			ovf = 1'b1;
			return SMAX;
		end
		if (v < 128'(signed'(SMIN))) begin
			ovf = 1'b1;
			return SMIN;
		end
		return v[31:0];
	endfunction

	// Truncating fixed-point product sum: shift down by the fraction bits, then saturate.
	function automatic logic signed [31:0] fix_sum(input logic signed [127:0] s, inout bit ovf);
		return saturate(s >>> FB, ovf);
	endfunction

	function automatic logic signed [127:0] wmul(input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic signed [127:0] wx;
		logic signed [127:0] wy;
		wx = x;
		wy = y;
		return wx * wy;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int bitpos = 48; bitpos >= 0; bitpos--) begin
			trial = root | (64'd1 << bitpos);
			if ({64'd0, trial} * {64'd0, trial} <= s)
				root = trial;
		end
		return root;
	endfunction

	// Predict the response for one request beat.
	function automatic quat_rsp_t predict_quat(input quat_req_t q);
		quat_rsp_t p;
		bit ovf;
		logic [127:0] sumsq;
		logic [63:0] len;
		logic [127:0] quot;
		logic [127:0] mag_a;
		ovf = 1'b0;
		for (int i = 0; i < 4; i++)
			p.r[i] = '0;
		p.magnitude = '0;
		p.are_equal = 1'b0;
		p.fault = FLT_NONE;
		case (q.command)
			CMD_MUL: begin
				p.r[0] = fix_sum(wmul(q.a[0], q.b[3]) + wmul(q.a[3], q.b[0])
					+ wmul(q.a[1], q.b[2]) - wmul(q.a[2], q.b[1]), ovf);
				p.r[1] = fix_sum(wmul(q.a[1], q.b[3]) + wmul(q.a[3], q.b[1])
					+ wmul(q.a[2], q.b[0]) - wmul(q.a[0], q.b[2]), ovf);
				p.r[2] = fix_sum(wmul(q.a[2], q.b[3]) + wmul(q.a[3], q.b[2])
					+ wmul(q.a[0], q.b[1]) - wmul(q.a[1], q.b[0]), ovf);
				p.r[3] = fix_sum(wmul(q.a[3], q.b[3]) - wmul(q.a[0], q.b[0])
					- wmul(q.a[1], q.b[1]) - wmul(q.a[2], q.b[2]), ovf);
			end
			CMD_SCALE: begin
				for (int i = 0; i < 4; i++)
					p.r[i] = fix_sum(wmul(q.a[i], q.factor), ovf);
			end
			CMD_CONJ: begin
				for (int i = 0; i < 3; i++)
					p.r[i] = saturate(-128'(q.a[i]), ovf);
				p.r[3] = q.a[3];
			end
			CMD_LEN, CMD_NORM: begin
				sumsq = '0;
				for (int i = 0; i < 4; i++)
					sumsq = sumsq + wmul(q.a[i], q.a[i]);
				len = floor_sqrt(sumsq);
				if (len > 64'hffff_ffff) begin
					p.magnitude = '1;
					ovf = 1'b1;
				end else begin
					p.magnitude = len[31:0];
				end
				if (q.command == CMD_NORM) begin
					if (len == 0) begin
						p.magnitude = '0;
						p.fault = FLT_ZERO;
					end else begin
						for (int i = 0; i < 4; i++) begin
							mag_a = q.a[i] < 0 ? -128'(q.a[i]) : 128'(q.a[i]);
							quot = (mag_a << FB) / {64'd0, len};
							if (q.a[i] < 0)
								p.r[i] = saturate(-$signed(quot), ovf);
							else
								p.r[i] = saturate($signed(quot), ovf);
						end
					end
				end
			end
			CMD_EQ: p.are_equal = (q.a[0] == q.b[0]) && (q.a[1] == q.b[1])
				&& (q.a[2] == q.b[2]) && (q.a[3] == q.b[3]);
			default: ;
		endcase
		if (p.fault == FLT_NONE && ovf)
			p.fault = FLT_SAT;
		return p;
	endfunction

	function automatic quat_req_t make_req(input logic [2:0] command,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] az, input logic signed [31:0] aw,
			input logic signed [31:0] bx, input logic signed [31:0] by,
			input logic signed [31:0] bz, input logic signed [31:0] bw,
			input logic signed [31:0] factor);
		quat_req_t q;
		q.command = command;
		q.a = '{ax, ay, az, aw};
		q.b = '{bx, by, bz, bw};
		q.factor = factor;
		return q;
	endfunction

	function automatic quat_rsp_t make_rsp(input logic signed [31:0] rx,
			input logic signed [31:0] ry, input logic signed [31:0] rz,
			input logic signed [31:0] rw, input logic [31:0] magnitude,
			input logic are_equal, input logic [1:0] fault);
		quat_rsp_t p;
		p.r = '{rx, ry, rz, rw};
		p.magnitude = magnitude;
		p.are_equal = are_equal;
		p.fault = fault;
		return p;
	endfunction

	function automatic logic signed [31:0] rand_component();
		// Small values half the time so products stay in range, otherwise full width, zero or extremes.
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2, 3: return $urandom;
			4: return 32'sd0;
			default: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic quat_req_t rand_req();
		quat_req_t q;
		q.command = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(CMD_MUL, CMD_EQ));
		for (int i = 0; i < 4; i++) begin
			q.a[i] = rand_component();
			q.b[i] = rand_component();
		end
		q.factor = rand_component();
		// Equality is only interesting when the operands often match.
		if (q.command == CMD_EQ && $urandom_range(0, 1))
			for (int i = 0; i < 4; i++)
				q.b[i] = ($urandom_range(0, 5) == 0) ? rand_component() : q.a[i];
		return q;
	endfunction

	// Drive one request beat, idling first at random, and wait until it is accepted.
	task automatic send_beat(input quat_req_t q, input bit known, input quat_rsp_t rsp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= q.command;
		req_ch.a_x <= q.a[0];
		req_ch.a_y <= q.a[1];
		req_ch.a_z <= q.a[2];
		req_ch.a_w <= q.a[3];
		req_ch.b_x <= q.b[0];
		req_ch.b_y <= q.b[1];
		req_ch.b_z <= q.b[2];
		req_ch.b_w <= q.b[3];
		req_ch.factor <= q.factor;
		do
			@(posedge clk);
		while (!req_ch.ready);
		// The expectation is queued at the accepting edge, before the response can return.
		expected_rsps.push_back(known ? rsp : predict_quat(q));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: ready follows the idle percentage, or stays low during a forced hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Response checker: every accepted response beat is compared with the oldest expectation.
	always @(posedge clk) begin
		quat_rsp_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("response beat with no request outstanding");
				error_count++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp_ch.r_x !== exp_rsp.r[0]) begin
					$error("r_x expected %h actual %h", exp_rsp.r[0], rsp_ch.r_x);
					error_count++;
				end
				if (rsp_ch.r_y !== exp_rsp.r[1]) begin
					$error("r_y expected %h actual %h", exp_rsp.r[1], rsp_ch.r_y);
					error_count++;
				end
				if (rsp_ch.r_z !== exp_rsp.r[2]) begin
					$error("r_z expected %h actual %h", exp_rsp.r[2], rsp_ch.r_z);
					error_count++;
				end
				if (rsp_ch.r_w !== exp_rsp.r[3]) begin
					$error("r_w expected %h actual %h", exp_rsp.r[3], rsp_ch.r_w);
					error_count++;
				end
				if (rsp_ch.magnitude !== exp_rsp.magnitude) begin
					$error("magnitude expected %h actual %h", exp_rsp.magnitude,
						rsp_ch.magnitude);
					error_count++;
				end
				if (rsp_ch.are_equal !== exp_rsp.are_equal) begin
					$error("are_equal expected %b actual %b", exp_rsp.are_equal,
						rsp_ch.are_equal);
					error_count++;
				end
				if (rsp_ch.fault !== exp_rsp.fault) begin
					$error("fault expected %0d actual %0d", exp_rsp.fault, rsp_ch.fault);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("quaternion_arithmetic_unit verification failed");
			$finish;
		end
	end

	// Main stimulus.
	initial begin
		vector_t   directed [$];
		quat_rsp_t none;
		none = make_rsp(0, 0, 0, 0, 0, 1'b0, FLT_NONE);

		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_MUL;
		req_ch.a_x <= '0;
		req_ch.a_y <= '0;
		req_ch.a_z <= '0;
		req_ch.a_w <= '0;
		req_ch.b_x <= '0;
		req_ch.b_y <= '0;
		req_ch.b_z <= '0;
		req_ch.b_w <= '0;
		req_ch.factor <= '0;

		// Directed table. Rows marked known carry a response that is plain from the math.
		directed = '{
			// Identity times identity.
			'{make_req(CMD_MUL, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1'b1,
				make_rsp(0, 0, 0, ONE, 0, 1'b0, FLT_NONE)},
			// i times j is k.
			'{make_req(CMD_MUL, ONE, 0, 0, 0, 0, ONE, 0, 0, 0), 1'b1,
				make_rsp(0, 0, ONE, 0, 0, 1'b0, FLT_NONE)},
			// Product of the largest values saturates every lane.
			'{make_req(CMD_MUL, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 0), 1'b0, none},
			'{make_req(CMD_MUL, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0), 1'b0, none},
			'{make_req(CMD_MUL, -1, 1, -1, 1, 1, -1, 1, -1, 0), 1'b0, none},
			'{make_req(CMD_SCALE, ONE, -ONE, 2 * ONE, 0, 0, 0, 0, 0, ONE), 1'b1,
				make_rsp(ONE, -ONE, 2 * ONE, 0, 0, 1'b0, FLT_NONE)},
			'{make_req(CMD_SCALE, SMAX, SMIN, 1, -1, 0, 0, 0, 0, SMIN), 1'b0, none},
			// A tiny negative product truncates toward minus infinity.
			'{make_req(CMD_SCALE, -1, 1, 0, -1, 0, 0, 0, 0, 1), 1'b1,
				make_rsp(-1, 0, 0, -1, 0, 1'b0, FLT_NONE)},
			'{make_req(CMD_CONJ, ONE, -ONE, 3, 7, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(-ONE, ONE, -3, 7, 0, 1'b0, FLT_NONE)},
			// Conjugate of the most negative component saturates.
			'{make_req(CMD_CONJ, SMIN, SMAX, 0, SMIN, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(SMAX, SMIN + 1, 0, SMIN, 0, 1'b0, FLT_SAT)},
			'{make_req(CMD_LEN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(0, 0, 0, 0, 0, 1'b0, FLT_NONE)},
			'{make_req(CMD_LEN, 3, 4, 0, 0, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(0, 0, 0, 0, 5, 1'b0, FLT_NONE)},
			// Length of all-extreme components exceeds the range and saturates.
			'{make_req(CMD_LEN, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(0, 0, 0, 0, 32'hffff_ffff, 1'b0, FLT_SAT)},
			'{make_req(CMD_LEN, SMAX, SMAX, SMAX, SMAX, 0, 0, 0, 0, 0), 1'b0, none},
			// Normalize of a zero-length quaternion.
			'{make_req(CMD_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(0, 0, 0, 0, 0, 1'b0, FLT_ZERO)},
			'{make_req(CMD_NORM, 0, 0, 0, 2 * ONE, 0, 0, 0, 0, 0), 1'b1,
				make_rsp(0, 0, 0, ONE, 2 * ONE, 1'b0, FLT_NONE)},
			// A length of one raw unit makes the quotient exactly one.
			'{make_req(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none},
			'{make_req(CMD_NORM, -1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none},
			'{make_req(CMD_NORM, SMIN, SMAX, SMIN, SMAX, 0, 0, 0, 0, 0), 1'b0, none},
			'{make_req(CMD_EQ, 1, 2, 3, 4, 1, 2, 3, 4, 0), 1'b1,
				make_rsp(0, 0, 0, 0, 0, 1'b1, FLT_NONE)},
			'{make_req(CMD_EQ, SMIN, SMAX, -1, 0, SMIN, SMAX, -1, 1, 0), 1'b1, none},
			// Unused command codes return all zeros.
			'{make_req(3'd6, SMAX, SMAX, 1, 1, 1, 1, 1, 1, SMAX), 1'b1, none},
			'{make_req(3'd7, SMIN, 1, 1, 1, SMIN, 1, 1, 1, SMIN), 1'b1, none}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: sender idles little, receiver idles much.
		foreach (directed[i])
			send_beat(directed[i].req, directed[i].known, directed[i].rsp);
		for (int n = 0; n < 130; n++)
			send_beat(rand_req(), 1'b0, none);

		// Sender pauses until every outstanding response has come back.
		wait_drained();

		// Long receiver hold-off while the sender streams, so the pipeline fills and stalls.
		send_idle_pct = 0;
		fork
			begin
				recv_hold = 1'b1;
				repeat (200) @(posedge clk);
				recv_hold = 1'b0;
			end
		join_none
		for (int n = 0; n < 100; n++)
			send_beat(rand_req(), 1'b0, none);

		// Phase two: roles swapped.
		send_idle_pct = 65;
		recv_idle_pct = 23;
		for (int n = 0; n < 110; n++)
			send_beat(rand_req(), 1'b0, none);

		// Phase three: no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int n = 0; n < 110; n++)
			send_beat(rand_req(), 1'b0, none);

		wait_drained();
		repeat (LATENCY) @(posedge clk);
		stimulus_done = 1'b1;
	end

	// Final verdict once stimulus has drained.
	initial begin
		wait (stimulus_done);
		if (error_count == 0 && expected_rsps.size() == 0)
			$display("quaternion_arithmetic_unit verification clean");
		else
			$display("quaternion_arithmetic_unit verification failed");
		$finish;
	end

endmodule
